/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the stable priority queue
// Payload structs, operation and status codes, controller states and the
// command/status structs exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEF_CAPACITY = 16;

    // operation codes
    localparam logic [2:0] OP_ENQUEUE     = 3'd0;
    localparam logic [2:0] OP_DEQ_HEAD    = 3'd1;
    localparam logic [2:0] OP_DEQ_EXACT   = 3'd2;
    localparam logic [2:0] OP_DEQ_ATLEAST = 3'd3;
    localparam logic [2:0] OP_CLEAR       = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         priority_req;
        logic signed [31:0] item_value;
    } t_spq_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         removed_priority;
        logic signed [31:0] removed_value;
        logic [4:0]         occupancy;
    } t_spq_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_RESP
    } t_spq_state;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_POP_HEAD,
        ACT_POP_MATCH,
        ACT_CLEAR
    } t_spq_act;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       compare;
        logic       apply;
        t_spq_act   act;
        logic [1:0] status;
    } t_spq_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] operation;
        logic       full;
        logic       empty;
        logic       head_ge;
        logic       found;
    } t_spq_stat;

endpackage

/* rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl: operation sequencer
// Accepts one request, steps it through compare and apply, holds the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  spq_pkg::t_spq_stat i_stat,
    output spq_pkg::t_spq_cmd  o_cmd
);
    import spq_pkg::*;

    t_spq_state r_state;
    t_spq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: n_state = S_RESP;
            S_RESP:  if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.act     = ACT_NONE;
        o_cmd.status  = ST_NONE;
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.compare = (r_state == S_CMP);
        o_cmd.apply   = (r_state == S_APPLY);
        if (r_state == S_APPLY) begin
            unique case (i_stat.operation)
                OP_ENQUEUE: begin
                    o_cmd.act    = i_stat.full ? ACT_NONE : ACT_INSERT;
                    o_cmd.status = i_stat.full ? ST_FULL : ST_OK;
                end
                OP_DEQ_HEAD: begin
                    o_cmd.act    = i_stat.empty ? ACT_NONE : ACT_POP_HEAD;
                    o_cmd.status = i_stat.empty ? ST_NONE : ST_OK;
                end
                OP_DEQ_EXACT: begin
                    o_cmd.act    = i_stat.found ? ACT_POP_MATCH : ACT_NONE;
                    o_cmd.status = i_stat.found ? ST_OK : ST_NONE;
                end
                OP_DEQ_ATLEAST: begin
                    o_cmd.act    = i_stat.head_ge ? ACT_POP_HEAD : ACT_NONE;
                    o_cmd.status = i_stat.head_ge ? ST_OK : ST_NONE;
                end
                OP_CLEAR: begin
                    o_cmd.act    = ACT_CLEAR;
                    o_cmd.status = ST_OK;
                end
                default: begin
                    o_cmd.act    = ACT_NONE;
                    o_cmd.status = ST_NONE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESP);

    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && i_in_valid) |=> (r_state == S_CMP))
        else $error("accepted transfer did not enter compare");
    a_no_accept_in_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result is pending");
    a_apply_then_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> o_out_valid)
        else $error("apply not followed by a result");

endmodule

/* rtl/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath: sorted cell chain
// One cell per slot, kept in descending priority. Compare registers per-cell
// flags; apply shifts each cell from a neighbor or loads the new pair.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_spq_in   i_in_data,
    input  spq_pkg::t_spq_cmd  i_cmd,
    output spq_pkg::t_spq_stat o_stat,
    output spq_pkg::t_spq_out  o_out_data
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [7:0]         r_pri [CAPACITY];
    logic signed [31:0] r_val [CAPACITY];
    logic [7:0]         n_pri [CAPACITY];
    logic signed [31:0] n_val [CAPACITY];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    t_spq_in            r_req;
    logic [CAPACITY-1:0] r_lt;    // slot is free or below the request
    logic [CAPACITY-1:0] r_le;    // slot holds priority at or below request
    logic                r_found;
    logic                r_head_ge;
    logic [7:0]          r_rm_pri;
    logic signed [31:0]  r_rm_val;
    t_spq_out            r_out;

    logic [CAPACITY-1:0] c_valid;
    logic [CAPACITY-1:0] c_eq;
    logic [CAPACITY-1:0] c_first;
    logic [CAPACITY-1:0] c_shift_up;
    logic [7:0]          c_sel_pri;
    logic signed [31:0]  c_sel_val;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign c_valid[g] = (CW'(g) < r_count);
            assign c_eq[g]    = c_valid[g] && (r_pri[g] == r_req.priority_req);
            if (g == 0) begin : g_head
                assign c_first[g] = c_eq[g];
            end else begin : g_body
                assign c_first[g] = c_eq[g] && !c_eq[g-1];
            end
            assign c_shift_up[g] = (i_cmd.act == ACT_POP_HEAD) ||
                                   ((i_cmd.act == ACT_POP_MATCH) && r_le[g]);

            always_comb begin
                n_pri[g] = r_pri[g];
                n_val[g] = r_val[g];
                if (i_cmd.act == ACT_INSERT) begin
                    if (g == 0) begin
                        if (r_lt[g]) begin
                            n_pri[g] = r_req.priority_req;
                            n_val[g] = r_req.item_value;
                        end
                    end else if (r_lt[g] && !r_lt[(g == 0) ? 0 : g-1]) begin
                        n_pri[g] = r_req.priority_req;
                        n_val[g] = r_req.item_value;
                    end else if (r_lt[g]) begin
                        n_pri[g] = r_pri[(g == 0) ? 0 : g-1];
                        n_val[g] = r_val[(g == 0) ? 0 : g-1];
                    end
                end else if (c_shift_up[g] && (g < CAPACITY - 1)) begin
                    n_pri[g] = r_pri[(g < CAPACITY - 1) ? g+1 : g];
                    n_val[g] = r_val[(g < CAPACITY - 1) ? g+1 : g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.apply) begin
                    r_pri[g] <= n_pri[g];
                    r_val[g] <= n_val[g];
                end
                if (i_cmd.compare) begin
                    r_lt[g] <= !c_valid[g] || (r_pri[g] < r_req.priority_req);
                    r_le[g] <= c_valid[g] && (r_pri[g] <= r_req.priority_req);
                end
            end
        end
    endgenerate

    // one-hot AND-OR pick of the oldest exact match
    always_comb begin
        c_sel_pri = '0;
        c_sel_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            c_sel_pri = c_sel_pri | (r_pri[i] & {8{c_first[i]}});
            c_sel_val = c_sel_val | (r_val[i] & {32{c_first[i]}});
        end
    end

    always_comb begin
        n_count = r_count;
        case (i_cmd.act)
            ACT_INSERT:                  n_count = r_count + CW'(1);
            ACT_POP_HEAD, ACT_POP_MATCH: n_count = r_count - CW'(1);
            ACT_CLEAR:                   n_count = '0;
            default:                     n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_data;
        end
        if (i_cmd.compare) begin
            r_found   <= |c_eq;
            r_head_ge <= c_valid[0] && (r_pri[0] >= r_req.priority_req);
            r_rm_pri  <= c_sel_pri;
            r_rm_val  <= c_sel_val;
        end
        if (i_cmd.apply) begin
            r_out.status    <= i_cmd.status;
            r_out.occupancy <= 5'(n_count);
            case (i_cmd.act)
                ACT_POP_HEAD: begin
                    r_out.removed_priority <= r_pri[0];
                    r_out.removed_value    <= r_val[0];
                end
                ACT_POP_MATCH: begin
                    r_out.removed_priority <= r_rm_pri;
                    r_out.removed_value    <= r_rm_val;
                end
                default: begin
                    r_out.removed_priority <= '0;
                    r_out.removed_value    <= '0;
                end
            endcase
        end
    end

    assign o_stat.operation = r_req.operation;
    assign o_stat.full      = (r_count >= CW'(CAPACITY));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.head_ge   = r_head_ge;
    assign o_stat.found     = r_found;
    assign o_out_data       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && i_cmd.act == ACT_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");
    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && i_cmd.act == ACT_INSERT) |-> !o_stat.full)
        else $error("insert into a full queue");

endmodule

/* rtl/stable_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue_core: bounded priority queue, FIFO among equal keys
// Holds up to CAPACITY priority/value pairs, highest priority at the head.
//
// Input channel: i_in_valid / o_in_stall carry one operation per transfer
//   (enqueue, dequeue head, dequeue exact priority, dequeue at least a
//   priority, clear). A transfer happens on a rising edge with valid high
//   and stall low.
// Output channel: o_out_valid / i_out_stall return one result per request:
//   status, the removed pair (zero if none) and occupancy after the step.
// Sequence: after the input transfer the controller steps through compare
//   and apply, then holds the result valid until it transfers. Requests
//   are taken one at a time; a new request is not accepted until the result
//   of the last one transfers. The fixed sequence of the controller (compare
//   all cells, then shift the chain) sets the pace.
// Output stall: the result is held in its register and the input side stays
//   stalled until the result transfers.
// Reset: synchronous, active low; the queue is empty afterward. Slot contents
//   are not cleared, only the entry count.
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  spq_pkg::t_spq_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output spq_pkg::t_spq_out o_out_data
);
    import spq_pkg::*;

    // command and status between sequencer and cell chain
    t_spq_cmd  w_cmd;
    t_spq_stat w_stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // the cell chain keeps order; compare flags are registered before the shift
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stable_priority_queue_core
// Random and directed operations go in through the valid/stall request
// channel. A sorted-queue model predicts each result, and every result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import spq_pkg::*;

    localparam int CAPACITY       = DEF_CAPACITY;
    localparam int RESET_CYCLES   = 10;
    localparam int TARGET_ITEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int TAIL_CYCLES    = 12;    // leave some margin after the last result
    localparam int HOLD_AFTER     = 300;   // results seen before the long hold
    localparam int HOLD_CYCLES    = 150;

    // highest code the 3-bit operation field can carry; codes above
    // OP_CLEAR are unused and must leave the queue alone
    localparam logic [2:0] OP_CODE_MAX = 3'd7;

    typedef struct {
        t_spq_in req;
        bit      wait_idle;  // hold this request back until no result is due
    } t_pending;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_spq_in  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_spq_out o_out_data;

    // request stream, filled up front; results predicted but not yet seen
    t_pending request_q[$];
    t_spq_out outcome_q[$];

    // shadow of the queue contents, slot 0 is the head
    logic [7:0]  slot_pri [CAPACITY];
    logic [31:0] slot_val [CAPACITY];
    int          held = 0;

    int errors = 0;
    int accepted = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit in_taken = 1'b0;

    // coverage tallies for the closing summary
    int n_enq = 0, n_full = 0, n_pop_ok = 0, n_miss = 0, n_clear = 0;
    int n_unused = 0, peak_held = 0;

    stable_priority_queue_core #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sorted-queue model
    // ------------------------------------------------------------------

    // Pull entry idx out, close the hole, and report it as removed.
    function automatic t_spq_out take_entry(int idx, t_spq_out res);
        res.status           = ST_OK;
        res.removed_priority = slot_pri[idx];
        res.removed_value    = slot_val[idx];
        for (int i = idx; i + 1 < held; i++) begin
            slot_pri[i] = slot_pri[i + 1];
            slot_val[i] = slot_val[i + 1];
        end
        held--;
        return res;
    endfunction

    function automatic t_spq_out sorted_queue_step(t_spq_in req);
        t_spq_out res;
        int       pos;
        res        = '0;
        res.status = ST_NONE;
        case (req.operation)
            OP_ENQUEUE: begin
                n_enq++;
                if (held >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    // goes behind every entry of equal or higher priority,
                    // which keeps equal priorities in arrival order
                    pos = 0;
                    while (pos < held && slot_pri[pos] >= req.priority_req)
                        pos++;
                    for (int i = held; i > pos; i--) begin
                        slot_pri[i] = slot_pri[i - 1];
                        slot_val[i] = slot_val[i - 1];
                    end
                    slot_pri[pos] = req.priority_req;
                    slot_val[pos] = req.item_value;
                    held++;
                    res.status = ST_OK;
                end
            end
            OP_DEQ_HEAD: begin
                if (held > 0)
                    res = take_entry(0, res);
            end
            OP_DEQ_EXACT: begin
                // first hit from the head is the oldest of that priority
                pos = 0;
                while (pos < held && slot_pri[pos] != req.priority_req)
                    pos++;
                if (pos < held)
                    res = take_entry(pos, res);
            end
            OP_DEQ_ATLEAST: begin
                // sorted, so only the head can qualify
                if (held > 0 && slot_pri[0] >= req.priority_req)
                    res = take_entry(0, res);
            end
            OP_CLEAR: begin
                n_clear++;
                held       = 0;
                res.status = ST_OK;
            end
            default: begin
                n_unused++;
            end
        endcase
        res.occupancy = held[4:0];

        if (res.status == ST_FULL)
            n_full++;
        else if (res.status == ST_NONE)
            n_miss++;
        else if (req.operation != OP_ENQUEUE && req.operation != OP_CLEAR)
            n_pop_ok++;
        if (held > peak_held)
            peak_held = held;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_request(logic [2:0] op, logic [7:0] pri, logic [31:0] val,
                                 bit wait_idle);
        t_pending p;
        p.req.operation    = op;
        p.req.priority_req = pri;
        p.req.item_value   = val;
        p.wait_idle        = wait_idle;
        request_q.push_back(p);
    endtask

    // Mostly near a per-sequence base so that equal priorities and exact
    // matches are common; sometimes the extremes or anything at all.
    function automatic logic [7:0] pick_pri(logic [7:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 8'h00;
        else if (r < 10)
            return 8'hFF;
        else if (r < 35)
            return 8'($urandom_range(0, 255));
        else
            return 8'(base + $urandom_range(0, 3));
    endfunction

    function automatic logic [2:0] pick_removal();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return OP_DEQ_HEAD;
        else if (r == 1)
            return OP_DEQ_EXACT;
        else
            return OP_DEQ_ATLEAST;
    endfunction

    function automatic logic [2:0] pick_unused();
        logic [2:0] op;
        op = 3'($urandom_range(OP_CLEAR + 1, OP_CODE_MAX));
        return op;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stim_proc
        int         kind;
        int         len;
        int         r;
        logic [7:0] base;
        bit         pause;

        // empty-queue removals, clear and unused codes
        queue_request(OP_DEQ_HEAD,    8'h00, 32'h0, 1'b0);
        queue_request(OP_DEQ_EXACT,   8'hFF, 32'h0, 1'b0);
        queue_request(OP_DEQ_ATLEAST, 8'h00, 32'h0, 1'b0);
        queue_request(OP_CLEAR,       8'h00, 32'h0, 1'b0);
        for (int op = OP_CLEAR + 1; op <= OP_CODE_MAX; op++)
            queue_request(3'(op), 8'hFF, 32'hFFFF_FFFF, 1'b0);
        // field extremes; the two 255 entries must come out in order
        queue_request(OP_ENQUEUE, 8'h00, 32'h8000_0000, 1'b0);
        queue_request(OP_ENQUEUE, 8'hFF, 32'h7FFF_FFFF, 1'b0);
        queue_request(OP_ENQUEUE, 8'h80, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_ENQUEUE, 8'hFF, 32'h0000_0000, 1'b0);
        queue_request(OP_DEQ_EXACT,   8'hFF, 32'h0, 1'b0);  // oldest 255
        queue_request(OP_DEQ_EXACT,   8'h07, 32'h0, 1'b0);  // no such priority
        queue_request(OP_DEQ_ATLEAST, 8'hFF, 32'h0, 1'b0);  // head qualifies
        queue_request(OP_DEQ_ATLEAST, 8'hC8, 32'h0, 1'b0);  // head too low
        queue_request(OP_DEQ_HEAD,    8'h00, 32'h0, 1'b0);
        queue_request(OP_CLEAR,       8'h00, 32'h0, 1'b0);  // clear non-empty
        queue_request(OP_DEQ_HEAD,    8'h00, 32'h0, 1'b0);

        // Random part, in sequences. The first one waits for every result
        // to come back before it starts.
        pause = 1'b1;
        while (request_q.size() < TARGET_ITEMS) begin
            kind = $urandom_range(0, 99);
            base = 8'($urandom_range(0, 255));
            if (kind < 30) begin
                // fill up to or past capacity, then take some back out
                if ($urandom_range(0, 1))
                    queue_request(OP_CLEAR, 8'($urandom), $urandom, pause);
                else
                    queue_request(OP_DEQ_HEAD, 8'($urandom), $urandom, pause);
                len = $urandom_range(12, 20);
                repeat (len)
                    queue_request(OP_ENQUEUE, pick_pri(base), $urandom, 1'b0);
                len = $urandom_range(4, 18);
                repeat (len)
                    queue_request(pick_removal(), pick_pri(base), $urandom, 1'b0);
            end else if (kind < 85) begin
                // mix of enqueues, removals, clears and unused codes
                len = $urandom_range(15, 40);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        queue_request(OP_ENQUEUE, pick_pri(base), $urandom,
                                      pause && k == 0);
                    else if (r < 92)
                        queue_request(pick_removal(), pick_pri(base), $urandom,
                                      pause && k == 0);
                    else if (r < 96)
                        queue_request(OP_CLEAR, 8'($urandom), $urandom, pause && k == 0);
                    else
                        queue_request(pick_unused(), 8'($urandom), $urandom,
                                      pause && k == 0);
                end
            end else begin
                // noise: removals with arbitrary keys, clears, unused codes
                len = $urandom_range(3, 10);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        queue_request(pick_removal(), 8'($urandom), $urandom,
                                      pause && k == 0);
                    else if (r < 8)
                        queue_request(pick_unused(), 8'($urandom), $urandom,
                                      pause && k == 0);
                    else
                        queue_request(OP_CLEAR, 8'($urandom), $urandom, pause && k == 0);
                end
            end
            pause = ($urandom_range(0, 7) == 0);
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent, every prediction checked, then a short tail
        // to catch stray results
        while (request_q.size() != 0 || i_in_valid || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d operations: %0d enqueues (%0d rejected full), %0d removals",
                 accepted, n_enq, n_full, n_pop_ok);
        $display("  %0d clears, %0d unused codes, %0d empty/no-match, peak fill %0d of %0d",
                 n_clear, n_unused, n_miss, peak_held, CAPACITY);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: changes on the falling edge. After each transfer a
    // random gap may follow; some stretches run with no gaps at all.
    // ------------------------------------------------------------------
    int gap_left = 0;
    int gapless_items = 0;

    function automatic int next_gap();
        int r;
        if (gapless_items > 0) begin
            gapless_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            gapless_items = $urandom_range(30, 120);
            return 0;
        end else if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end else begin
            return $urandom_range(20, 40);
        end
    endfunction

    always @(negedge i_clk) begin : drive_proc
        t_pending nxt;
        bit       load;
        load = 1'b0;
        if (i_rst_n) begin
            if (in_taken)
                gap_left = next_gap();
            if (in_taken || !i_in_valid) begin
                if (gap_left > 0)
                    gap_left--;
                else if (request_q.size() != 0 &&
                         !(request_q[0].wait_idle && outcome_q.size() != 0))
                    load = 1'b1;
            end
            if (load) begin
                nxt = request_q.pop_front();
                i_in_data  <= nxt.req;
                i_in_valid <= 1'b1;
            end else if (in_taken) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side stall: random bursts, stall-free stretches, and one long
    // hold while the sender keeps offering so the block backs up.
    // ------------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  stall_left = 0;
    int  free_left = 0;

    always @(negedge i_clk) begin : stall_proc
        int r;
        bit stall_next;
        stall_next = 1'b0;
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (!hold_done && results_seen >= HOLD_AFTER && i_in_valid) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                stall_next = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else if (free_left > 0) begin
                free_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    free_left = $urandom_range(50, 200);
                end else if (r < 72) begin
                    stall_next = 1'b0;
                end else if (r < 92) begin
                    stall_left = $urandom_range(0, 2);
                    stall_next = 1'b1;
                end else if (r < 98) begin
                    stall_left = $urandom_range(3, 11);
                    stall_next = 1'b1;
                end else begin
                    stall_left = $urandom_range(19, 39);
                    stall_next = 1'b1;
                end
            end
        end
        i_out_stall <= stall_next;
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, check any result transfer against the
    // oldest prediction, then predict for any request transfer.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_proc
        t_spq_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with none pending, expected nothing, actual %p",
                             $time, o_out_data);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 32'(want.status),
                                        32'(o_out_data.status));
                    if (o_out_data.removed_priority !== want.removed_priority)
                        report_mismatch("removed_priority", 32'(want.removed_priority),
                                        32'(o_out_data.removed_priority));
                    if (o_out_data.removed_value !== want.removed_value)
                        report_mismatch("removed_value", want.removed_value,
                                        o_out_data.removed_value);
                    if (o_out_data.occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(want.occupancy),
                                        32'(o_out_data.occupancy));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                accepted++;
                outcome_q.push_back(sorted_queue_step(i_in_data));
            end
        end
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
    end

    // watchdog: any transfer on either side counts as progress
    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, outcome_q.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* files.f */
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/stable_priority_queue_core.sv
bench/testbench.sv
